>>> src/vector_magnitude_limit_2d_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the vector magnitude limiter
// Concurrent checks clocked on clk and quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef VECTOR_MAGNITUDE_LIMIT_2D_ASSERT_SVH
`define VECTOR_MAGNITUDE_LIMIT_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define VML_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vml assertion failed");
`define VML_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vml implication failed");
`else
`define VML_ASSERT(label, prop)
`define VML_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

>>> src/vml_pkg.sv
// ---------------------------------------------------------------------------
// vml_pkg
// Shared constants and types of the vector magnitude limiter.
// ---------------------------------------------------------------------------
package vml_pkg;

    localparam int DATA_WIDTH_DEF = 16;

    // per-word side flags carried down the cell chains
    typedef struct packed {
        logic clamp;
        logic neg_x;
        logic neg_y;
    } vml_flag_t;

    localparam int FLAG_W = $bits(vml_flag_t);

endpackage

>>> src/vml_if.sv
// ---------------------------------------------------------------------------
// vml_in_if / vml_out_if
// Valid/ready channels for input vectors and limited results.
// ---------------------------------------------------------------------------
interface vml_in_if #(parameter int W = 16);
    logic                 valid;
    logic                 ready;
    logic signed [W-1:0]  vec_x;
    logic signed [W-1:0]  vec_y;
    logic        [W-2:0]  max_length;

    modport source (output valid, vec_x, vec_y, max_length, input ready);
    modport sink   (input valid, vec_x, vec_y, max_length, output ready);
endinterface

interface vml_out_if #(parameter int W = 16);
    logic                 valid;
    logic                 ready;
    logic signed [W-1:0]  out_x;
    logic signed [W-1:0]  out_y;
    logic                 was_clamped;

    modport source (output valid, out_x, out_y, was_clamped, input ready);
    modport sink   (input valid, out_x, out_y, was_clamped, output ready);
endinterface

>>> src/vml_sqrt_cell.sv
// ---------------------------------------------------------------------------
// vml_sqrt_cell
// One digit step of the integer square root: resolves one root bit.
// ---------------------------------------------------------------------------
module vml_sqrt_cell
    import vml_pkg::*;
#(
    parameter int W  = DATA_WIDTH_DEF,
    parameter int PW = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*W-1:0]  in_src,
    input  logic [W+1:0]    in_rem,
    input  logic [W-1:0]    in_root,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [2*W-1:0]  out_src,
    output logic [W+1:0]    out_rem,
    output logic [W-1:0]    out_root,
    output logic [PW-1:0]   out_pay
);

    logic [W+3:0] r2;
    logic [W+3:0] trial;
    logic [W+3:0] diff;
    logic         ge;

    // bring in two radicand bits and try the next root bit
    always_comb
    begin
        r2    = {in_rem, in_src[2*W-1 -: 2]};
        trial = {2'b00, in_root, 2'b01};
        diff  = r2 - trial;
        ge    = (r2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_src  <= {in_src[2*W-3:0], 2'b00};
            out_rem  <= ge ? diff[W+1:0] : r2[W+1:0];
            out_root <= {in_root[W-2:0], ge};
            out_pay  <= in_pay;
        end
    end

endmodule

>>> src/vml_div_cell.sv
// ---------------------------------------------------------------------------
// vml_div_cell
// One restoring division step for the x and y lanes over a shared divisor.
// ---------------------------------------------------------------------------
module vml_div_cell
    import vml_pkg::*;
#(
    parameter int W  = DATA_WIDTH_DEF,
    parameter int PW = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [W-1:0]    in_div,
    input  logic [W-1:0]    in_rem_x,
    input  logic [W-1:0]    in_rem_y,
    input  logic [W-2:0]    in_num_x,
    input  logic [W-2:0]    in_num_y,
    input  logic [W-2:0]    in_quo_x,
    input  logic [W-2:0]    in_quo_y,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [W-1:0]    out_div,
    output logic [W-1:0]    out_rem_x,
    output logic [W-1:0]    out_rem_y,
    output logic [W-2:0]    out_num_x,
    output logic [W-2:0]    out_num_y,
    output logic [W-2:0]    out_quo_x,
    output logic [W-2:0]    out_quo_y,
    output logic [PW-1:0]   out_pay
);

    logic [W:0] r2_x;
    logic [W:0] r2_y;
    logic [W:0] d_x;
    logic [W:0] d_y;
    logic       ge_x;
    logic       ge_y;

    // shift in one numerator bit per lane and subtract when it fits
    always_comb
    begin
        r2_x = {in_rem_x, in_num_x[W-2]};
        r2_y = {in_rem_y, in_num_y[W-2]};
        ge_x = (r2_x >= {1'b0, in_div});
        ge_y = (r2_y >= {1'b0, in_div});
        d_x  = r2_x - {1'b0, in_div};
        d_y  = r2_y - {1'b0, in_div};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_div   <= in_div;
            out_rem_x <= ge_x ? d_x[W-1:0] : r2_x[W-1:0];
            out_rem_y <= ge_y ? d_y[W-1:0] : r2_y[W-1:0];
            out_num_x <= {in_num_x[W-3:0], 1'b0};
            out_num_y <= {in_num_y[W-3:0], 1'b0};
            out_quo_x <= {in_quo_x[W-3:0], ge_x};
            out_quo_y <= {in_quo_y[W-3:0], ge_y};
            out_pay   <= in_pay;
        end
    end

endmodule

>>> src/vector_magnitude_limit_2d.sv
// ---------------------------------------------------------------------------
// vector_magnitude_limit_2d
// Clamps the magnitude of a signed fixed-point 2D vector to a limit.
// ---------------------------------------------------------------------------
// Usage:
//   vec_ch carries one word per vector: vec_x, vec_y (signed) and
//   max_length (unsigned). res_ch returns one word per vector: out_x, out_y
//   and was_clamped, in input order.
//   A vector whose sum of squares exceeds max_length squared is scaled by
//   max_length / floor(sqrt(x*x + y*y)), truncated toward zero.
//   Accepts one vector per cycle while res_ch does not stall. From
//   acceptance to res_ch a vector passes two stages of multiply and
//   compare, a row of DATA_WIDTH square-root cells, one root bit each, a
//   row of DATA_WIDTH-1 divider cells, one quotient bit each, and the
//   output register.
//   When res_ch stalls with a word waiting, the whole row of cells holds
//   and vec_ch.ready drops in the same cycle; no word is lost.
//   Reset clears every valid bit; no result is shown until a new vector
//   comes through. There is no configuration.
// ---------------------------------------------------------------------------
`include "vector_magnitude_limit_2d_assert.svh"

module vector_magnitude_limit_2d
    import vml_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    vml_in_if.sink            vec_ch,
    vml_out_if.source         res_ch
);

    localparam int W   = DATA_WIDTH;
    localparam int NW  = 2*W - 2;
    localparam int SPW = 2*W + FLAG_W + 2*NW;
    localparam int DPW = 2*W + FLAG_W;

    logic en;

    // ---- stage A: magnitudes and products -------------------------------
    logic [W-1:0]   ax;
    logic [W-1:0]   ay;
    logic           a_valid_reg;
    vml_flag_t      a_flags_reg;
    logic [W-1:0]   a_x_reg;
    logic [W-1:0]   a_y_reg;
    logic [2*W-1:0] a_sqx_reg;
    logic [2*W-1:0] a_sqy_reg;
    logic [NW-1:0]  a_lsq_reg;
    logic [NW-1:0]  a_nx_reg;
    logic [NW-1:0]  a_ny_reg;
    logic [2*W-2:0] prod_lsq;
    logic [2*W-2:0] prod_nx;
    logic [2*W-2:0] prod_ny;

    // ---- stage B: sum of squares and compare ----------------------------
    logic           b_valid_reg;
    logic [2*W-1:0] b_sum_reg;
    logic [SPW-1:0] b_pay_reg;
    logic [2*W-1:0] sum_next;
    vml_flag_t      b_flags_next;

    // ---- cell rows --------------------------------------------------------
    logic           sq_valid [0:W];
    logic [2*W-1:0] sq_src   [0:W];
    logic [W+1:0]   sq_rem   [0:W];
    logic [W-1:0]   sq_root  [0:W];
    logic [SPW-1:0] sq_pay   [0:W];

    logic           dv_valid [0:W-1];
    logic [W-1:0]   dv_div   [0:W-1];
    logic [W-1:0]   dv_rem_x [0:W-1];
    logic [W-1:0]   dv_rem_y [0:W-1];
    logic [W-2:0]   dv_num_x [0:W-1];
    logic [W-2:0]   dv_num_y [0:W-1];
    logic [W-2:0]   dv_quo_x [0:W-1];
    logic [W-2:0]   dv_quo_y [0:W-1];
    logic [DPW-1:0] dv_pay   [0:W-1];

    logic [NW-1:0]  sq_nx_end;
    logic [NW-1:0]  sq_ny_end;
    logic [DPW-1:0] sq_dpay_end;

    // ---- output stage -----------------------------------------------------
    logic           o_valid_reg;
    logic [W-1:0]   o_x_reg;
    logic [W-1:0]   o_y_reg;
    logic           o_clamp_reg;
    vml_flag_t      e_flags;
    logic [W-1:0]   e_x;
    logic [W-1:0]   e_y;
    logic [W-1:0]   e_qx;
    logic [W-1:0]   e_qy;
    logic [W-1:0]   e_ax;

    // advance the whole row unless a finished word is stuck at the output
    assign en           = !o_valid_reg || res_ch.ready;
    assign vec_ch.ready = en;

    // form magnitudes of the components and their products with the limit
    always_comb
    begin
        ax       = vec_ch.vec_x[W-1] ? (~vec_ch.vec_x + 1'b1) : vec_ch.vec_x;
        ay       = vec_ch.vec_y[W-1] ? (~vec_ch.vec_y + 1'b1) : vec_ch.vec_y;
        prod_lsq = vec_ch.max_length * vec_ch.max_length;
        prod_nx  = ax * vec_ch.max_length;
        prod_ny  = ay * vec_ch.max_length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= vec_ch.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // register squares and numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_flags_reg.clamp <= 1'b0;
            a_flags_reg.neg_x <= vec_ch.vec_x[W-1];
            a_flags_reg.neg_y <= vec_ch.vec_y[W-1];
            a_x_reg           <= vec_ch.vec_x;
            a_y_reg           <= vec_ch.vec_y;
            a_sqx_reg         <= ax * ax;
            a_sqy_reg         <= ay * ay;
            a_lsq_reg         <= prod_lsq[NW-1:0];
            a_nx_reg          <= prod_nx[NW-1:0];
            a_ny_reg          <= prod_ny[NW-1:0];
        end
    end

    // add squares and compare against the limit squared
    always_comb
    begin
        sum_next           = a_sqx_reg + a_sqy_reg;
        b_flags_next       = a_flags_reg;
        b_flags_next.clamp = (sum_next > {2'b00, a_lsq_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sum_reg <= sum_next;
            b_pay_reg <= {a_x_reg, a_y_reg, b_flags_next, a_nx_reg, a_ny_reg};
        end
    end

    // square-root row, one root bit per cell
    assign sq_valid[0] = b_valid_reg;
    assign sq_src[0]   = b_sum_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_pay[0]   = b_pay_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_sqrt
        vml_sqrt_cell #(
            .W  (W),
            .PW (SPW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_src    (sq_src[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_pay    (sq_pay[i]),
            .out_valid (sq_valid[i+1]),
            .out_src   (sq_src[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_pay   (sq_pay[i+1])
        );
    end

    // split the payload and seed the divider row
    assign sq_ny_end   = sq_pay[W][NW-1:0];
    assign sq_nx_end   = sq_pay[W][2*NW-1:NW];
    assign sq_dpay_end = sq_pay[W][SPW-1:2*NW];

    assign dv_valid[0] = sq_valid[W];
    assign dv_div[0]   = sq_root[W];
    assign dv_rem_x[0] = {1'b0, sq_nx_end[NW-1:W-1]};
    assign dv_rem_y[0] = {1'b0, sq_ny_end[NW-1:W-1]};
    assign dv_num_x[0] = sq_nx_end[W-2:0];
    assign dv_num_y[0] = sq_ny_end[W-2:0];
    assign dv_quo_x[0] = '0;
    assign dv_quo_y[0] = '0;
    assign dv_pay[0]   = sq_dpay_end;

    // divider row, one quotient bit per cell
    for (genvar j = 0; j < W-1; j++)
    begin : g_div
        vml_div_cell #(
            .W  (W),
            .PW (DPW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[j]),
            .in_div    (dv_div[j]),
            .in_rem_x  (dv_rem_x[j]),
            .in_rem_y  (dv_rem_y[j]),
            .in_num_x  (dv_num_x[j]),
            .in_num_y  (dv_num_y[j]),
            .in_quo_x  (dv_quo_x[j]),
            .in_quo_y  (dv_quo_y[j]),
            .in_pay    (dv_pay[j]),
            .out_valid (dv_valid[j+1]),
            .out_div   (dv_div[j+1]),
            .out_rem_x (dv_rem_x[j+1]),
            .out_rem_y (dv_rem_y[j+1]),
            .out_num_x (dv_num_x[j+1]),
            .out_num_y (dv_num_y[j+1]),
            .out_quo_x (dv_quo_x[j+1]),
            .out_quo_y (dv_quo_y[j+1]),
            .out_pay   (dv_pay[j+1])
        );
    end

    // restore signs and pick scaled or original components
    always_comb
    begin
        e_flags = dv_pay[W-1][FLAG_W-1:0];
        e_y     = dv_pay[W-1][FLAG_W +: W];
        e_x     = dv_pay[W-1][FLAG_W+W +: W];
        e_qx    = e_flags.neg_x ? (~{1'b0, dv_quo_x[W-1]} + 1'b1) : {1'b0, dv_quo_x[W-1]};
        e_qy    = e_flags.neg_y ? (~{1'b0, dv_quo_y[W-1]} + 1'b1) : {1'b0, dv_quo_y[W-1]};
        e_ax    = e_x[W-1] ? (~e_x + 1'b1) : e_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dv_valid[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_x_reg     <= e_flags.clamp ? e_qx : e_x;
            o_y_reg     <= e_flags.clamp ? e_qy : e_y;
            o_clamp_reg <= e_flags.clamp;
        end
    end

    assign res_ch.valid       = o_valid_reg;
    assign res_ch.out_x       = o_x_reg;
    assign res_ch.out_y       = o_y_reg;
    assign res_ch.was_clamped = o_clamp_reg;

    // checks
    `VML_ASSERT_IMPLY(a_root_nonzero, sq_valid[W] && sq_dpay_end[FLAG_W-1], sq_root[W] != '0)
    `VML_ASSERT_IMPLY(a_quo_bounded, dv_valid[W-1] && e_flags.clamp, {1'b0, dv_quo_x[W-1]} <= e_ax)
    `VML_ASSERT(a_clamp_in_range, !(o_valid_reg && o_clamp_reg && o_x_reg == {1'b1, {(W-1){1'b0}}}))

endmodule

>>> bench/tb_vml_chan.sv
// ---------------------------------------------------------------------------
// Bench handshake helpers
// Source-side and sink-side wrappers are not needed; the RTL interfaces are
// driven directly. This file holds the payload types used by the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_vml_pkg;

    // one vector word as offered on the input channel
    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic        [14:0] lim;
    } vec_word_t;

    // one limited result word
    typedef struct {
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic               clamped;
    } lim_word_t;

    // row of the directed table; chk_res says the result is typed in
    typedef struct {
        vec_word_t w;
        logic      chk_res;
        lim_word_t r;
    } stim_row_t;

endpackage

>>> bench/tb.sv
// ---------------------------------------------------------------------------
// tb: vector magnitude limiter bench
// Drives a directed table and then random vectors through the limiter with
// random gaps on both channels, predicts every result in the bench and
// compares each returned word field by field in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import tb_vml_pkg::*;

    localparam int N_RANDOM   = 850;
    localparam int LATENCY    = 34;
    localparam int CYCLE_CAP  = 400000;
    localparam int N_DIRECTED = 14;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;
    bit   long_hold;
    bit   feed_done;

    vml_in_if  #(.W(16)) vec_ch ();
    vml_out_if #(.W(16)) res_ch ();

    lim_word_t expected_q[$];

    vector_magnitude_limit_2d uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .vec_ch (vec_ch.sink),
        .res_ch (res_ch.source)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // floor square root, one bit per step
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // compute the limited vector
    function automatic lim_word_t limit_vector(vec_word_t w);
        lim_word_t       r;
        longint unsigned ax, ay, lim, sumsq, mag, qx, qy;
        ax    = (w.vx < 0) ? longint'(-int'(w.vx)) : longint'(w.vx);
        ay    = (w.vy < 0) ? longint'(-int'(w.vy)) : longint'(w.vy);
        lim   = w.lim;
        sumsq = ax * ax + ay * ay;
        if (sumsq > lim * lim)
        begin
            mag       = isqrt(sumsq);
            qx        = (ax * lim) / mag;
            qy        = (ay * lim) / mag;
            r.rx      = (w.vx < 0) ? -16'(qx) : 16'(qx);
            r.ry      = (w.vy < 0) ? -16'(qy) : 16'(qy);
            r.clamped = 1'b1;
        end
        else
        begin
            r.rx      = w.vx;
            r.ry      = w.vy;
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    // directed table: extremes, zero vector, zero limit, most negative parts
    function automatic stim_row_t row(int x, int y, int l, bit c, int ex, int ey, bit ec);
        stim_row_t s;
        s.w.vx      = 16'(x);
        s.w.vy      = 16'(y);
        s.w.lim     = 15'(l);
        s.chk_res   = c;
        s.r.rx      = 16'(ex);
        s.r.ry      = 16'(ey);
        s.r.clamped = ec;
        return s;
    endfunction

    stim_row_t directed[N_DIRECTED];

    initial
    begin
        directed[0]  = row(0, 0, 0, 1, 0, 0, 0);
        directed[1]  = row(0, 0, 32767, 1, 0, 0, 0);
        directed[2]  = row(1, 0, 0, 1, 0, 0, 1);
        directed[3]  = row(-32768, -32768, 0, 1, 0, 0, 1);
        directed[4]  = row(-32768, 0, 32767, 1, -32767, 0, 1);
        directed[5]  = row(-32768, 0, 32767, 1, -32767, 0, 1);
        directed[6]  = row(32767, 32767, 32767, 0, 0, 0, 0);
        directed[7]  = row(-32768, -32768, 32767, 0, 0, 0, 0);
        directed[8]  = row(300, -400, 500, 1, 300, -400, 0);
        directed[9]  = row(300, -400, 499, 0, 0, 0, 0);
        directed[10] = row(256, 0, 256, 1, 256, 0, 0);
        directed[11] = row(-1, -1, 1, 0, 0, 0, 0);
        directed[12] = row(0, -32768, 32767, 0, 0, 0, 0);
        directed[13] = row(21845, -10923, 100, 0, 0, 0, 0);
    end

    // offer one word and wait for its acceptance; valid stays high between
    // back-to-back words and drops only for an idle gap
    task automatic send_word(vec_word_t w);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            vec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_ch.valid      <= 1'b1;
        vec_ch.vec_x      <= w.vx;
        vec_ch.vec_y      <= w.vy;
        vec_ch.max_length <= w.lim;
        @(posedge clk);
        while (!vec_ch.ready) @(posedge clk);
    endtask

    // random vector, biased toward the clamp boundary and small limits
    function automatic vec_word_t rand_word();
        vec_word_t w;
        int        k;
        w.vx  = 16'($urandom);
        w.vy  = 16'($urandom);
        w.lim = 15'($urandom);
        k     = $urandom_range(0, 7);
        if (k == 0)
            w.lim = 15'($urandom_range(0, 3));
        else if (k == 1)
        begin
            w.vx  = 16'($signed($urandom_range(0, 600)) - 300);
            w.vy  = 16'($signed($urandom_range(0, 600)) - 300);
            w.lim = 15'($urandom_range(0, 450));
        end
        else if (k == 2)
        begin
            w.vx = 16'h8000;
        end
        else if (k == 3)
        begin
            w.vx = 16'd0;
            w.vy = 16'd0;
        end
        return w;
    endfunction

    // stimulus
    initial
    begin
        stim_row_t s;
        vec_word_t w;
        vec_ch.valid      <= 1'b0;
        vec_ch.vec_x      <= '0;
        vec_ch.vec_y      <= '0;
        vec_ch.max_length <= '0;
        feed_done = 1'b0;
        long_hold = 1'b0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // walk the directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            s = directed[i];
            if (s.chk_res)
                expected_q.push_back(s.r);
            else
                expected_q.push_back(limit_vector(s.w));
            send_word(s.w);
        end
        vec_ch.valid <= 1'b0;
        // pause until the directed results have all drained
        while (expected_q.size() != 0) @(posedge clk);
        // random vectors, with one long receiver hold-off partway through
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 200)
                long_hold <= 1'b1;
            w = rand_word();
            expected_q.push_back(limit_vector(w));
            send_word(w);
        end
        vec_ch.valid <= 1'b0;
        feed_done    <= 1'b1;
    end

    // result side: random stalls, plus a long hold-off when requested
    initial
    begin
        int wait_n;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold <= 1'b0;
            end
            wait_n = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0)
                wait_n = 0;
            if (wait_n != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        lim_word_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_ch.out_x !== e.rx)
                begin
                    $error("out_x expected %0d got %0d", e.rx, res_ch.out_x);
                    errors++;
                end
                if (res_ch.out_y !== e.ry)
                begin
                    $error("out_y expected %0d got %0d", e.ry, res_ch.out_y);
                    errors++;
                end
                if (res_ch.was_clamped !== e.clamped)
                begin
                    $error("was_clamped expected %0b got %0b", e.clamped,
                           res_ch.was_clamped);
                    errors++;
                end
            end
        end
    end

    // end of run and watchdog
    initial
    begin
        errors = 0;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else if (feed_done && expected_q.size() == 0)
            begin
                repeat (LATENCY + 10) @(posedge clk);
                if (errors == 0 && expected_q.size() == 0)
                    $display("end of test: clean");
                else
                    $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
